// ===== hw/rtl/ltc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_pkg: shared types and constants of the lidar return converter
// Widths, CORDIC constants, the elevation table and the saturation helper.
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int LASER_COUNT_DEF = 32;
  localparam int ELEV_ROWS       = 32;
  localparam int CORDIC_STEPS    = 16;

  // Widths of the CORDIC datapath.
  localparam int XY_W = 19;
  localparam int Z_W  = 20;

  // Fold, scale and input stages, the rotation cells, and the final sign stage.
  localparam int TRIG_LAT = 3 + CORDIC_STEPS + 1;

  localparam logic [15:0] AZ_TURN      = 16'd36000;
  localparam logic [15:0] AZ_HALF_TURN = 16'd18000;
  localparam logic [15:0] AZ_QUARTER   = 16'd9000;
  localparam logic [15:0] AZ_3QUARTER  = 16'd27000;

  localparam logic [19:0] CDEG_TO_RAD_Q16 = 20'd749613;
  localparam logic signed [XY_W-1:0] CORDIC_START = 19'sd39797;

  localparam logic [15:0] MAX_RANGE_RST = 16'd5000;
  localparam logic signed [19:0] COORD_LIMIT = 20'sd131070;

  localparam logic signed [Z_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2
  };

  // Elevation of each row in centidegrees, negative angles wrapped by a full turn.
  localparam logic [15:0] ELEV_ANGLE [ELEV_ROWS] = '{
    16'd32933, 16'd33067, 16'd33200, 16'd33333, 16'd33467, 16'd33600,
    16'd33733, 16'd33867, 16'd34000, 16'd34133, 16'd34267, 16'd34400,
    16'd34533, 16'd34667, 16'd34800, 16'd34933, 16'd35067, 16'd35200,
    16'd35333, 16'd35467, 16'd35600, 16'd35733, 16'd35867, 16'd0,
    16'd133,   16'd267,   16'd400,   16'd533,   16'd667,   16'd800,
    16'd933,   16'd1067
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } cordic_vec_t;

  function automatic logic signed [17:0] sat_coord(input logic signed [19:0] v);
    logic signed [19:0] r;
    r = v;
    if (v > COORD_LIMIT) begin
      r = COORD_LIMIT;
    end else if (v < -COORD_LIMIT) begin
      r = -COORD_LIMIT;
    end
    return r[17:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ltc_angle_prep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_angle_prep: angle fold and conversion to radians
// Folds a centidegree angle into a quarter turn either side of zero and scales
// it to Q16 radians, giving the starting vector of the rotation chain.
// ----------------------------------------------------------------------------
module ltc_angle_prep import ltc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic [15:0] angle_i,
  output cordic_vec_t      vec_o
);

  logic [13:0] mag_d, mag_q;
  logic        neg_d, neg_q, neg2_q;
  logic        flip_d, flip_q, flip2_q;
  logic [33:0] prod;
  logic [16:0] scaled_d, scaled_q;
  cordic_vec_t vec_d, vec_q;

  always_comb begin
    mag_d  = angle_i[13:0];
    neg_d  = 1'b0;
    flip_d = 1'b0;
    if (angle_i > AZ_3QUARTER) begin
      mag_d = 14'(AZ_TURN - angle_i);
      neg_d = 1'b1;
    end else if (angle_i > AZ_QUARTER) begin
      // The half-turn fold flips the sign of both sine and cosine.
      flip_d = 1'b1;
      if (angle_i >= AZ_HALF_TURN) begin
        mag_d = 14'(angle_i - AZ_HALF_TURN);
      end else begin
        mag_d = 14'(AZ_HALF_TURN - angle_i);
        neg_d = 1'b1;
      end
    end
  end

  assign prod     = 34'(mag_q) * 34'(CDEG_TO_RAD_Q16) + 34'd32768;
  assign scaled_d = prod[32:16];

  always_comb begin
    vec_d.x    = CORDIC_START;
    vec_d.y    = '0;
    vec_d.z    = neg2_q ? -$signed({3'b000, scaled_q}) : $signed({3'b000, scaled_q});
    vec_d.flip = flip2_q;
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    flip_q   <= flip_d;
    scaled_q <= scaled_d;
    neg2_q   <= neg_q;
    flip2_q  <= flip_q;
    vec_q    <= vec_d;
  end

  assign vec_o = vec_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ltc_cordic_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_cordic_cell: one rotation step of the CORDIC chain
// Rotates the vector by the step's arctangent in the direction that drives the
// residual angle toward zero, and registers the result for the next cell.
// ----------------------------------------------------------------------------
module ltc_cordic_cell import ltc_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic        clk_i,
  input  wire cordic_vec_t vec_i,
  output cordic_vec_t      vec_o
);

  logic signed [XY_W-1:0] dx, dy;
  cordic_vec_t            vec_d, vec_q;

  assign dx = vec_i.y >>> STEP;
  assign dy = vec_i.x >>> STEP;

  always_comb begin
    vec_d.flip = vec_i.flip;
    // A residual of zero turns the positive way.
    if (!vec_i.z[Z_W-1]) begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - ATAN_Q16[STEP];
    end else begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + ATAN_Q16[STEP];
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign vec_o = vec_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ltc_trig.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_trig: pipelined sine and cosine of a centidegree angle
// Angle fold and scaling, a row of rotation cells, then the fold's sign.
// ----------------------------------------------------------------------------
module ltc_trig import ltc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic [15:0]            angle_i,
  output logic signed [XY_W-1:0]      sin_o,
  output logic signed [XY_W-1:0]      cos_o
);

  cordic_vec_t            chain [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] sin_q, cos_q;

  ltc_angle_prep u_prep (
    .clk_i   (clk_i),
    .angle_i (angle_i),
    .vec_o   (chain[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    ltc_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk_i (clk_i),
      .vec_i (chain[i]),
      .vec_o (chain[i+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (chain[CORDIC_STEPS].flip) begin
      sin_q <= -chain[CORDIC_STEPS].y;
      cos_q <= -chain[CORDIC_STEPS].x;
    end else begin
      sin_q <= chain[CORDIC_STEPS].y;
      cos_q <= chain[CORDIC_STEPS].x;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lidar_return_to_cartesian_point.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_return_to_cartesian_point: lidar return to Cartesian point converter
// Turns one return of a spinning multi-laser lidar into x, y, z in millimetres.
// ----------------------------------------------------------------------------
// Usage
//   A request is taken at each rising edge with start high; busy is always
//   low, so a new request may be issued in every cycle and one request per
//   clock is sustained. The request carries azimuth, raw channel and raw
//   distance.
//   A request whose channel is not below the laser count, or whose distance is
//   not below max_raw_range, produces no point. Every other request produces
//   one point, shown for a single cycle with valid_o high. Points leave in
//   request order. Each request passes through the two sixteen-cell rotation
//   chains (azimuth and elevation run side by side), then the multiply and
//   rounding stages.
//   The receiver cannot stall the block; it must take each point as shown.
//   max_raw_range is written through max_raw_range_we_i; the user must write
//   it only while no request is in flight, which the block does not enforce.
//   Reset sets it to 5000 and empties the pipeline.
// ----------------------------------------------------------------------------
module lidar_return_to_cartesian_point import ltc_pkg::*; #(
  parameter int LASER_COUNT = LASER_COUNT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [15:0]        azimuth_centideg_i,
  input  wire logic [4:0]         raw_channel_i,
  input  wire logic [15:0]        raw_distance_i,
  input  wire logic               max_raw_range_we_i,
  input  wire logic [15:0]        max_raw_range_wdata_i,
  output logic                    valid_o,
  output logic signed [17:0]      x_mm_o,
  output logic signed [17:0]      y_mm_o,
  output logic signed [17:0]      z_mm_o,
  output logic [4:0]              elevation_row_o
);

  localparam int HALF       = LASER_COUNT / 2;
  localparam int ROW_CALC_W = $clog2(HALF + 16);
  localparam int P_W        = 34;
  localparam int RH_W       = 35;
  localparam int PZ_W       = 37;
  localparam int S_W        = 52;

  localparam logic signed [S_W-1:0]  HALF_Q32 = {{(S_W-32){1'b0}}, 1'b1, 31'b0};
  localparam logic signed [PZ_W-1:0] HALF_Q16 = {{(PZ_W-16){1'b0}}, 1'b1, 15'b0};

  logic accept;
  logic [15:0] max_raw_range_q;

  // Input stage.
  logic [ROW_CALC_W-1:0] row_full;
  logic                  ch_ok, row_ok, ok_d, ok_q;
  logic [15:0]           az_mod_d, az_mod_q;
  logic [4:0]            row_q;
  logic [15:0]           dist_q;

  // Trig results.
  logic signed [XY_W-1:0] sin_az, cos_az, sin_el, cos_el;

  // Delay line alongside the trig units.
  logic [TRIG_LAT-1:0] ok_line_q;
  logic [15:0]         dist_line_q [TRIG_LAT];
  logic [4:0]          row_line_q  [TRIG_LAT];

  // Product stages.
  logic [4:0]              v_q;
  logic [4:0]              row_m_q [5];
  logic signed [P_W-1:0]   pc_q, ps_q;
  logic signed [PZ_W-1:0]  pz_q, pz2_q;
  logic [16:0]             r_m1_q;
  logic signed [RH_W-1:0]  rch_q, rsh_q;
  logic [33:0]             rcl_q, rsl_q;
  logic signed [S_W-1:0]   sx_q, sy_q;
  logic signed [PZ_W-1:0]  zsum;
  logic signed [19:0]      zr_q, zr2_q;
  logic signed [S_W-1:0]   xsum, ysum;
  logic signed [19:0]      xr_q, yr_q;
  logic signed [17:0]      x_q, y_q, z_q;
  logic [16:0]             r_full;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_raw_range_q <= MAX_RANGE_RST;
    end else if (max_raw_range_we_i) begin
      max_raw_range_q <= max_raw_range_wdata_i;
    end
  end

  // Odd channels fill the upper half of the rows, even channels the lower half.
  assign row_full = raw_channel_i[0] ?
                    ROW_CALC_W'(HALF) + ROW_CALC_W'(raw_channel_i[4:1]) :
                    ROW_CALC_W'(raw_channel_i[4:1]);
  assign ch_ok    = {2'b00, raw_channel_i} < 7'(LASER_COUNT);
  assign row_ok   = 7'(row_full) < 7'(ELEV_ROWS);
  assign ok_d     = accept & ch_ok & row_ok & (raw_distance_i < max_raw_range_q);
  assign az_mod_d = (azimuth_centideg_i >= AZ_TURN) ? azimuth_centideg_i - AZ_TURN
                                                    : azimuth_centideg_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q      <= 1'b0;
      ok_line_q <= '0;
      v_q       <= '0;
    end else begin
      ok_q      <= ok_d;
      ok_line_q <= {ok_line_q[TRIG_LAT-2:0], ok_q};
      v_q       <= {v_q[3:0], ok_line_q[TRIG_LAT-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    az_mod_q <= az_mod_d;
    row_q    <= row_full[4:0];
    dist_q   <= raw_distance_i;
    dist_line_q[0] <= dist_q;
    row_line_q[0]  <= row_q;
    for (int i = 1; i < TRIG_LAT; i++) begin
      dist_line_q[i] <= dist_line_q[i-1];
      row_line_q[i]  <= row_line_q[i-1];
    end
  end

  ltc_trig u_trig_az (
    .clk_i   (clk_i),
    .angle_i (az_mod_q),
    .sin_o   (sin_az),
    .cos_o   (cos_az)
  );

  ltc_trig u_trig_el (
    .clk_i   (clk_i),
    .angle_i (ELEV_ANGLE[row_q]),
    .sin_o   (sin_el),
    .cos_o   (cos_el)
  );

  assign r_full = {dist_line_q[TRIG_LAT-1], 1'b0};

  // Rounding adds; the y coordinate is negated before it is rounded.
  assign zsum = pz2_q + HALF_Q16;
  assign xsum = sx_q + HALF_Q32;
  assign ysum = HALF_Q32 - sy_q;

  always_ff @(posedge clk_i) begin
    // Angle products, and r times the elevation sine.
    pc_q   <= P_W'(cos_el) * P_W'(cos_az);
    ps_q   <= P_W'(cos_el) * P_W'(sin_az);
    pz_q   <= PZ_W'($signed({1'b0, r_full})) * PZ_W'(sin_el);
    r_m1_q <= r_full;
    row_m_q[0] <= row_line_q[TRIG_LAT-1];

    // r times the angle products, split into high and low partial products.
    rch_q <= RH_W'($signed({1'b0, r_m1_q})) * RH_W'($signed(pc_q[33:17]));
    rcl_q <= 34'(r_m1_q) * 34'(pc_q[16:0]);
    rsh_q <= RH_W'($signed({1'b0, r_m1_q})) * RH_W'($signed(ps_q[33:17]));
    rsl_q <= 34'(r_m1_q) * 34'(ps_q[16:0]);
    pz2_q <= pz_q;
    row_m_q[1] <= row_m_q[0];

    sx_q  <= (S_W'(rch_q) <<< 17) + $signed({18'b0, rcl_q});
    sy_q  <= (S_W'(rsh_q) <<< 17) + $signed({18'b0, rsl_q});
    zr_q  <= zsum[35:16];
    row_m_q[2] <= row_m_q[1];

    xr_q  <= xsum[S_W-1:32];
    yr_q  <= ysum[S_W-1:32];
    zr2_q <= zr_q;
    row_m_q[3] <= row_m_q[2];

    x_q   <= sat_coord(xr_q);
    y_q   <= sat_coord(yr_q);
    z_q   <= sat_coord(zr2_q);
    row_m_q[4] <= row_m_q[3];
  end

  assign valid_o         = v_q[4];
  assign x_mm_o          = x_q;
  assign y_mm_o          = y_q;
  assign z_mm_o          = z_q;
  assign elevation_row_o = row_m_q[4];

endmodule
`default_nettype wire
